### rtl/core/assert_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FVWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FVWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fvws_pkg.sv
`default_nettype none

package fvws_pkg;

    // Voices and table geometry
    localparam int NUM_VOICES = 4;
    localparam int TABLE_SIZE = 1000;
    localparam int FRAC_W     = 16;
    localparam int PHASE_W    = 26;
    localparam int IDX_W      = PHASE_W - FRAC_W;
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 12;
    localparam int DAC_W      = 12;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Phase wrap amount: table size in 10.16 phase form, one bit wider than the phase
    localparam logic [PHASE_W:0] PHASE_WRAP = (PHASE_W + 1)'(TABLE_SIZE) << FRAC_W;

    // Output code range
    localparam int DAC_MID = 2048;
    localparam int DAC_MAX = 4095;

    // Sine table build constants (Q30 fixed point)
    localparam logic [63:0] Q15_MAX     = 64'd32767;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SERIES_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                64'd42, 64'd20, 64'd6};

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t sine_tab_t [TABLE_SIZE];

    // Register map, one step register per voice
    typedef enum logic [1:0] {
        REG_STEP_A,
        REG_STEP_B,
        REG_STEP_C,
        REG_STEP_D
    } reg_idx_t;

    // Step register write request into one voice
    typedef struct packed {
        logic               wr;
        logic [PHASE_W-1:0] data;
    } step_wr_t;

    // Occupancy of the mixer pipeline stages
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
        logic s3_valid;
    } mix_stat_t;

    // One table entry: odd-polynomial sine over a quarter wave, mirrored
    function automatic sample_t sine_entry(input int unsigned i);
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] mag;
        r = 64'(i) << 2;
        q = r / TABLE_SIZE;
        e = r % TABLE_SIZE;
        m = q[0] ? (64'(TABLE_SIZE) - e) : e;
        t = (m * HALF_PI_Q30) / TABLE_SIZE;
        t2 = (t * t) >> 30;
        acc = Q30_ONE;
        for (int k = 0; k < 6; k++)
        begin
            acc = Q30_ONE - (((t2 * acc) >> 30) / SERIES_DIV[k]);
        end
        s = (t * acc) >> 30;
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        mag = (Q15_MAX * s) >> 30;
        return (q >= 64'd2) ? -sample_t'(mag[SAMPLE_W-1:0]) : sample_t'(mag[SAMPLE_W-1:0]);
    endfunction

    // Whole table, evaluated at elaboration
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

### rtl/core/fvws_sine_rom.sv
`default_nettype none

module fvws_sine_rom (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [fvws_pkg::IDX_W-1:0] addr,
    output fvws_pkg::sample_t              rdata
);
    import fvws_pkg::*;

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    sample_t rdata_reg;
    sample_t rdata_next;

    // Read zero past the end of the table
    always_comb
    begin
        if ({1'b0, addr} < (IDX_W + 1)'(TABLE_SIZE))
        begin
            rdata_next = SINE_TAB[addr];
        end
        else
        begin
            rdata_next = '0;
        end
    end

    // Registered read, hold while not enabled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= rdata_next;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/fvws_voice.sv
`default_nettype none

module fvws_voice (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fvws_pkg::step_wr_t          step_wr,
    input  wire logic                        advance,
    output logic [fvws_pkg::IDX_W-1:0]       rom_addr,
    output logic [fvws_pkg::PHASE_W-1:0]     step
);
    import fvws_pkg::*;

    logic [PHASE_W-1:0] step_reg;
    logic [PHASE_W-1:0] step_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W:0]   phase_wrapped;
    logic [PHASE_W-1:0] phase_adv;

    // Add the step, drop one table length when the integer part reaches the table size
    always_comb
    begin
        phase_sum = {1'b0, phase_reg} + {1'b0, step_reg};
        if (phase_sum[PHASE_W:FRAC_W] >= (IDX_W + 1)'(TABLE_SIZE))
        begin
            phase_wrapped = phase_sum - PHASE_WRAP;
        end
        else
        begin
            phase_wrapped = phase_sum;
        end
        phase_adv = phase_wrapped[PHASE_W-1:0];
    end

    // Step write; a zero step also clears the phase
    always_comb
    begin
        step_next  = step_reg;
        phase_next = phase_reg;
        if (advance)
        begin
            phase_next = phase_adv;
        end
        if (step_wr.wr)
        begin
            step_next = step_wr.data;
            if (step_wr.data == '0)
            begin
                phase_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            phase_reg <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    // Table index of the advanced phase
    assign rom_addr = phase_adv[PHASE_W-1:FRAC_W];
    assign step     = step_reg;

endmodule

`default_nettype wire

### rtl/core/fvws_mixer.sv
`default_nettype none

module fvws_mixer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [fvws_pkg::VOL_W-1:0] volume,
    input  wire fvws_pkg::sample_t         samples [fvws_pkg::NUM_VOICES],
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [fvws_pkg::DAC_W-1:0]     dac_code,
    output fvws_pkg::mix_stat_t            stat
);
    import fvws_pkg::*;

    localparam int SUM_W   = SAMPLE_W + 2;
    localparam int PROD_W  = SUM_W + VOL_W + 1;
    localparam int SHIFT_W = PROD_W - FRAC_W;
    localparam int CODE_W  = SHIFT_W + 1;

    logic en1;
    logic en2;
    logic en3;
    logic en4;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic s3_valid_reg;
    logic s3_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic [VOL_W-1:0]          vol1_reg;
    logic [VOL_W-1:0]          vol2_reg;
    logic signed [SUM_W-1:0]   sum2_reg;
    logic signed [SUM_W-1:0]   sum2_next;
    logic signed [PROD_W-1:0]  prod3_reg;
    logic signed [PROD_W-1:0]  prod3_next;
    logic signed [VOL_W:0]     vol2_s;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [CODE_W-1:0]  code;
    logic [DAC_W-1:0]          dac_code_reg;
    logic [DAC_W-1:0]          dac_code_next;

    // Advance a stage when it is empty or its successor advances
    assign en4 = !out_valid_reg || out_ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    always_comb
    begin
        s1_valid_next  = en1 ? in_valid : s1_valid_reg;
        s2_valid_next  = en2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = en3 ? s2_valid_reg : s3_valid_reg;
        out_valid_next = en4 ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Mix the four voices
    always_comb
    begin
        sum2_next = SUM_W'(samples[0]) + SUM_W'(samples[1])
                  + SUM_W'(samples[2]) + SUM_W'(samples[3]);
    end

    // Scale by the request's volume
    always_comb
    begin
        vol2_s     = signed'({1'b0, vol2_reg});
        prod3_next = PROD_W'(sum2_reg) * PROD_W'(vol2_s);
    end

    // Floor shift, recenter at midscale and clamp to the DAC range
    always_comb
    begin
        shifted = prod3_reg[PROD_W-1:FRAC_W];
        code    = CODE_W'(shifted) + CODE_W'(DAC_MID);
        if (code > CODE_W'(DAC_MAX))
        begin
            dac_code_next = DAC_W'(DAC_MAX);
        end
        else if (code < 0)
        begin
            dac_code_next = '0;
        end
        else
        begin
            dac_code_next = code[DAC_W-1:0];
        end
    end

    // Payload stages, held while stalled
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            vol1_reg <= volume;
        end
        if (en2)
        begin
            vol2_reg <= vol1_reg;
            sum2_reg <= sum2_next;
        end
        if (en3)
        begin
            prod3_reg <= prod3_next;
        end
        if (en4)
        begin
            dac_code_reg <= dac_code_next;
        end
    end

    assign in_ready      = en1;
    assign out_valid     = out_valid_reg;
    assign dac_code      = dac_code_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;
    assign stat.s3_valid = s3_valid_reg;

endmodule

`default_nettype wire

### rtl/core/four_voice_wavetable_synth.sv
`default_nettype none

`include "assert_macros.svh"

// Four-voice wavetable synthesizer. Each accepted request is one sample tick
// with a 12-bit volume; every tick advances four 10.16 phase accumulators by
// their step registers, looks the four phases up in a 1000-entry Q15 sine
// table, sums them, scales by volume, floors by 2^16, adds midscale 2048 and
// clamps to a 12-bit DAC code. One request is taken every cycle unless output
// stalls have filled the pipeline; each result passes the table read register,
// then the mix, multiply and clamp registers, and stalls on the output back up
// through those four stages. Step registers sit at byte addresses 0, 4, 8 and
// 12 (voices A..D, low 26 bits of the write data); writing a zero step also
// clears that voice's phase. Write steps only while no tick is in flight.
module four_voice_wavetable_synth (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fvws_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fvws_pkg::DATA_W-1:0] pwdata,
    output logic [fvws_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [fvws_pkg::VOL_W-1:0]  volume,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [fvws_pkg::DAC_W-1:0]       dac_code
);
    import fvws_pkg::*;

    reg_idx_t           reg_idx;
    logic               cfg_wr;
    logic [NUM_VOICES-1:0] wr_sel;
    logic               in_accept;
    step_wr_t           step_wr [NUM_VOICES];
    logic [IDX_W-1:0]   rom_addr [NUM_VOICES];
    logic [PHASE_W-1:0] step [NUM_VOICES];
    sample_t            samples [NUM_VOICES];
    mix_stat_t          stat;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign in_accept = in_valid && in_ready;

    // Decode the step register select
    always_comb
    begin
        wr_sel = '0;
        unique case (reg_idx)
            REG_STEP_A: wr_sel[0] = 1'b1;
            REG_STEP_B: wr_sel[1] = 1'b1;
            REG_STEP_C: wr_sel[2] = 1'b1;
            REG_STEP_D: wr_sel[3] = 1'b1;
            default:    wr_sel = '0;
        endcase
    end

    // Read back the selected step
    always_comb
    begin
        unique case (reg_idx)
            REG_STEP_A: prdata = DATA_W'(step[0]);
            REG_STEP_B: prdata = DATA_W'(step[1]);
            REG_STEP_C: prdata = DATA_W'(step[2]);
            REG_STEP_D: prdata = DATA_W'(step[3]);
            default:    prdata = '0;
        endcase
    end

    for (genvar v = 0; v < NUM_VOICES; v++)
    begin : g_voice
        assign step_wr[v].wr   = cfg_wr && wr_sel[v];
        assign step_wr[v].data = pwdata[PHASE_W-1:0];

        fvws_voice u_voice (
            .clk      (clk),
            .rst_n    (rst_n),
            .step_wr  (step_wr[v]),
            .advance  (in_accept),
            .rom_addr (rom_addr[v]),
            .step     (step[v])
        );

        fvws_sine_rom u_rom (
            .clk   (clk),
            .en    (in_accept),
            .addr  (rom_addr[v]),
            .rdata (samples[v])
        );
    end

    fvws_mixer u_mixer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .volume    (volume),
        .samples   (samples),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dac_code  (dac_code),
        .stat      (stat)
    );

    // Input stalls only when a finished result is being held
    `FVWS_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready,
        "input stalled without output backpressure")
    // An accepted request lands in the first stage
    `FVWS_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_accept, stat.s1_valid,
        "accepted request missing from stage one")
    // No result appears from an empty last stage
    `FVWS_ASSERT_NEXT(a_no_phantom, clk, rst_n, !out_valid && !stat.s3_valid, !out_valid,
        "result produced without an item in flight")

endmodule

`default_nettype wire
